// ===== design/mpsh_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsh_pkg - shared types and constants of the multichannel regulator
// Item formats, the classified work entry passed from front to back,
// register indexes and the fixed limits of the control law.
// ----------------------------------------------------------------------------
package mpsh_pkg;

  // input item as seen on the port
  typedef struct packed {
    logic        command;
    logic [1:0]  channel;
    logic [15:0] value;
  } in_item_t;

  // result item as seen on the port
  typedef struct packed {
    logic [1:0]  out_channel;
    logic [15:0] drive;
    logic [6:0]  stop_countdown;
  } out_item_t;

  // input command codes
  localparam logic CMD_SET_TARGET = 1'b0;
  localparam logic CMD_MEASURE    = 1'b1;

  // classified operation carried through the queue
  typedef enum logic {
    OP_SET_TARGET = 1'b0,
    OP_MEASURE    = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  channel;
    logic [15:0] value;
  } work_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2
  } reg_index_t;

  // control law limits
  localparam logic signed [15:0] INTEG_LIMIT = 16'sd1000;
  localparam logic signed [15:0] SMALL_ERROR = 16'sd3;
  localparam logic [6:0]         HOLD_RELOAD = 7'd100;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== design/multichannel_pid_stop_hold.sv =====
// ----------------------------------------------------------------------------
// multichannel_pid_stop_hold - multichannel PID regulator with stop-hold
// Per-channel PID with clamped integral and a stop-hold countdown, built as
// an input stage, a short queue and a pipelined datapath.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle, set-target and measure items alike,
// unless out_ready stalls. A measure item passes the input register, queue,
// stage 1 register (channel state update), stage 2 register (gain products)
// and output register. The rate is set by the channel state update, a
// read-modify-write of the addressed channel, so items on the same channel
// may follow each other back to back. Set-target items and items for a channel
// at or above CHANNELS give no result. Gains are to be written through the
// configuration port while no item is in flight; the block does not enforce it.
module multichannel_pid_stop_hold
  import mpsh_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  logic  push_valid;
  logic  push_ready;
  work_t push_work;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_work;

  // accept and classify
  mpsh_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work)
  );

  // decoupling queue
  mpsh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_work   (pop_work)
  );

  // regulator datapath
  mpsh_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_work  (pop_work),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== design/mpsh_front.sv =====
// ----------------------------------------------------------------------------
// mpsh_front - input stage
// Registers each accepted item, decodes its command and drops items that
// address a channel that does not exist, then hands the work to the queue.
// ----------------------------------------------------------------------------
module mpsh_front
  import mpsh_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     push_valid,
  input  logic     push_ready,
  output work_t    push_work
);

  logic  held;
  work_t work;
  logic  in_range;
  logic  take;

  // channel range check and command decode
  assign in_range = int'(in_item.channel) < CHANNELS;
  assign in_ready = !held || push_ready;
  assign take     = in_valid && in_ready;

  // input register, empties into the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= in_range;
    end else if (push_ready) begin
      held <= 1'b0;
    end
    if (take) begin
      work.op      <= (in_item.command == CMD_MEASURE) ? OP_MEASURE : OP_SET_TARGET;
      work.channel <= in_item.channel;
      work.value   <= in_item.value;
    end
  end

  assign push_valid = held;
  assign push_work  = work;

endmodule

// ===== design/mpsh_queue.sv =====
// ----------------------------------------------------------------------------
// mpsh_queue - short work queue
// Two-entry first-in first-out buffer that lets the front and the back
// stall independently while sustaining one item per cycle.
// ----------------------------------------------------------------------------
module mpsh_queue
  import mpsh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_work,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_work
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_work   = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_work;
    end
  end

endmodule

// ===== design/mpsh_back.sv =====
// ----------------------------------------------------------------------------
// mpsh_back - regulator datapath
// Holds the gains and the per-channel state, updates a channel as its item
// enters the stage 1 register, forms the three gain products into the stage 2
// register and the drive sum in the output register.
// ----------------------------------------------------------------------------
module mpsh_back
  import mpsh_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  work_t       pop_work,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  // gains
  logic [15:0] gain_prop;
  logic [15:0] gain_integ;
  logic [15:0] gain_deriv;

  // per-channel state
  logic [15:0] target       [CHANNELS];
  logic [15:0] prev_error   [CHANNELS];
  logic [15:0] integral_sum [CHANNELS];
  logic [6:0]  hold_count   [CHANNELS];

  // channel state read
  logic [15:0] cur_target;
  logic [15:0] cur_prev;
  logic [15:0] cur_integ;
  logic [6:0]  cur_hold;

  // update stage results
  logic [15:0] err;
  logic [15:0] integ_raw;
  logic [15:0] integ;
  logic [15:0] deriv;
  logic        small_err;
  logic [6:0]  hold_next;
  logic        kill;
  logic [15:0] prev_store;
  logic [15:0] integ_store;

  // pipeline control
  logic        pop;
  logic        out_load;
  logic        s2_adv;
  logic        s1_adv;

  // stage 1: operands
  logic        s1_valid;
  logic [1:0]  s1_channel;
  logic [15:0] s1_err;
  logic [15:0] s1_integ;
  logic [15:0] s1_deriv;
  logic        s1_kill;
  logic [6:0]  s1_hold;

  // stage 2: products
  logic        s2_valid;
  logic [1:0]  s2_channel;
  logic [15:0] s2_prod_p;
  logic [15:0] s2_prod_i;
  logic [15:0] s2_prod_d;
  logic        s2_kill;
  logic [6:0]  s2_hold;

  logic [31:0] full_p;
  logic [31:0] full_i;
  logic [31:0] full_d;
  logic [15:0] drive_sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= '0;
      gain_integ <= '0;
      gain_deriv <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_PROP:  gain_prop  <= cfg_data;
        REG_GAIN_INTEG: gain_integ <= cfg_data;
        REG_GAIN_DERIV: gain_deriv <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall chain from the output register back to the queue
  assign out_load  = !out_valid || out_ready;
  assign s2_adv    = !s2_valid || out_load;
  assign s1_adv    = !s1_valid || s2_adv;
  assign pop_ready = s1_adv;
  assign pop       = pop_valid && s1_adv;

  // select the addressed channel's state
  always_comb begin
    cur_target = '0;
    cur_prev   = '0;
    cur_integ  = '0;
    cur_hold   = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (int'(pop_work.channel) == k) begin
        cur_target = target[k];
        cur_prev   = prev_error[k];
        cur_integ  = integral_sum[k];
        cur_hold   = hold_count[k];
      end
    end
  end

  // error, integral with reset and clamp, derivative, stop-hold
  always_comb begin
    err       = cur_target - pop_work.value;
    integ_raw = cur_integ + err;
    small_err = ($signed(err) > -SMALL_ERROR) && ($signed(err) < SMALL_ERROR)
                && (pop_work.value == '0);
    integ     = small_err ? '0 : integ_raw;
    if ($signed(integ) > INTEG_LIMIT) begin
      integ = INTEG_LIMIT;
    end else if ($signed(integ) < -INTEG_LIMIT) begin
      integ = -INTEG_LIMIT;
    end
    deriv       = err - cur_prev;
    kill        = 1'b0;
    hold_next   = cur_hold;
    prev_store  = err;
    integ_store = integ;
    if (cur_target != '0) begin
      hold_next = HOLD_RELOAD;
    end else if (cur_hold != '0) begin
      hold_next   = 7'(cur_hold - 7'd1);
      kill        = 1'b1;
      prev_store  = '0;
      integ_store = '0;
    end
  end

  // channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        target[k]       <= '0;
        prev_error[k]   <= '0;
        integral_sum[k] <= '0;
        hold_count[k]   <= '0;
      end
    end else if (pop) begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (int'(pop_work.channel) == k) begin
          if (pop_work.op == OP_SET_TARGET) begin
            target[k] <= pop_work.value;
          end else begin
            prev_error[k]   <= prev_store;
            integral_sum[k] <= integ_store;
            hold_count[k]   <= hold_next;
          end
        end
      end
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= pop && (pop_work.op == OP_MEASURE);
    end
    if (s1_adv) begin
      s1_channel <= pop_work.channel;
      s1_err     <= err;
      s1_integ   <= integ;
      s1_deriv   <= deriv;
      s1_kill    <= kill;
      s1_hold    <= hold_next;
    end
  end

  // gain products, low 16 bits kept
  assign full_p = gain_prop * s1_err;
  assign full_i = gain_integ * s1_integ;
  assign full_d = gain_deriv * s1_deriv;

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
    if (s2_adv) begin
      s2_channel <= s1_channel;
      s2_prod_p  <= full_p[15:0];
      s2_prod_i  <= full_i[15:0];
      s2_prod_d  <= full_d[15:0];
      s2_kill    <= s1_kill;
      s2_hold    <= s1_hold;
    end
  end

  // drive sum, forced to zero while stop-hold runs
  assign drive_sum = s2_prod_p + s2_prod_i + s2_prod_d;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s2_valid;
    end
    if (out_load) begin
      out_item.out_channel    <= s2_channel;
      out_item.drive          <= s2_kill ? '0 : drive_sum;
      out_item.stop_countdown <= s2_hold;
    end
  end

  // a measure on a channel with a nonzero target reloads the countdown
  a_reload : assert property (@(posedge clk) disable iff (rst)
    pop && (pop_work.op == OP_MEASURE) && (cur_target != '0)
    |=> s1_valid && (s1_hold == HOLD_RELOAD))
    else $error("stop countdown not reloaded");

  // the integral passed on is always inside its clamp
  a_clamp : assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($signed(s1_integ) <= INTEG_LIMIT) && ($signed(s1_integ) >= -INTEG_LIMIT))
    else $error("integral outside clamp");

  // a stop-hold step gives zero drive
  a_kill : assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_kill && out_load |=> out_valid && (out_item.drive == '0))
    else $error("drive not zero during stop-hold");

  // a set-target item gives no result
  a_set_silent : assert property (@(posedge clk) disable iff (rst)
    pop && (pop_work.op == OP_SET_TARGET) |=> !s1_valid)
    else $error("set-target item produced work");

endmodule
